// File: rtl/rrt_pkg.sv
// Shared types and constants for the response routing table.
`timescale 1ns / 1ps

package rrt_pkg;

   localparam int RRT_TABLE_DEPTH = 16;

   localparam int OP_W = 2;
   localparam int CLIENT_W = 32;
   localparam int DEVICE_W = 32;
   localparam int FUNCTION_W = 8;
   localparam int SEQUENCE_W = 4;

   typedef logic [OP_W-1:0] rrt_op_type;

   localparam rrt_op_type OP_RECORD = 2'd0;
   localparam rrt_op_type OP_ROUTE = 2'd1;
   localparam rrt_op_type OP_PURGE = 2'd2;

   typedef struct packed {
      logic [CLIENT_W-1:0]   client;
      logic [DEVICE_W-1:0]   device;
      logic [FUNCTION_W-1:0] function_id;
      logic [SEQUENCE_W-1:0] sequence_number;
   } rrt_entry_type;

   typedef struct packed {
      logic record;
      logic full;
      logic mark_route;
      logic mark_purge;
      logic squeeze;
   } rrt_ctrl_type;

endpackage

// File: rtl/rrt_cell.sv
// One table cell: holds an entry and its removal mark and shifts from its upper neighbor.
`timescale 1ns / 1ps

module rrt_cell
   import rrt_pkg::*;
#(
   parameter int TABLE_DEPTH = RRT_TABLE_DEPTH,
   parameter int INDEX = 0,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  rrt_ctrl_type        ctrl,
   input  rrt_entry_type       new_entry,
   input  logic [CNT_W-1:0]    count,
   input  rrt_entry_type       nb_entry,
   input  logic                nb_kill,
   input  logic                hole_in,
   input  logic [CLIENT_W-1:0] sel_in,
   output rrt_entry_type       entry,
   output logic                kill,
   output logic                hole_out,
   output logic [CLIENT_W-1:0] sel_out
);

   rrt_entry_type entry_ff, entry_in;
   logic          kill_ff, kill_in;
   logic          occupied, key_hit, client_hit, write_en, shift_en, lowest;

   always_comb begin
      occupied = CNT_W'(INDEX) < count;
      key_hit = (entry_ff.device == new_entry.device) &&
                (entry_ff.function_id == new_entry.function_id) &&
                (entry_ff.sequence_number == new_entry.sequence_number);
      client_hit = entry_ff.client == new_entry.client;
      hole_out = hole_in | kill_ff;
      lowest = kill_ff & ~hole_in;
      sel_out = sel_in | ({CLIENT_W{lowest}} & entry_ff.client);
      write_en = ctrl.record &&
                 (ctrl.full ? (INDEX == TABLE_DEPTH - 1) : (CNT_W'(INDEX) == count));
      shift_en = (ctrl.record && ctrl.full) || (ctrl.squeeze && hole_out);

      entry_in = entry_ff;
      if (write_en) begin
         entry_in = new_entry;
      end else if (shift_en) begin
         entry_in = nb_entry;
      end

      kill_in = kill_ff;
      if (ctrl.mark_route) begin
         kill_in = occupied && key_hit;
      end else if (ctrl.mark_purge) begin
         kill_in = occupied && client_hit;
      end else if (ctrl.squeeze && hole_out) begin
         kill_in = nb_kill;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         kill_ff <= 1'b0;
      end else begin
         kill_ff <= kill_in;
      end
   end

   assign entry = entry_ff;
   assign kill = kill_ff;

endmodule

// File: rtl/response_routing_table.sv
// Top level of the response routing table: control sequencer and the chain of cells.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   operation, client, device, function, seq, flag
//   rsp_     out        rsp_valid/rsp_ready   found, client, broadcast, dropped, counts
//
// Record, an unused operation code and a route with sequence number zero are answered straight from idle.
// A route that searches first marks matching cells, then removes the oldest marked entry.
// A purge marks every entry of the client, then the chain closes one gap a cycle until none is left.
// A new beat is taken when the sequencer is idle and the result register is free or emptying.
// Reset is synchronous and empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module response_routing_table
   import rrt_pkg::*;
#(
   parameter int TABLE_DEPTH = RRT_TABLE_DEPTH,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CLIENT_W-1:0]   req_client_id,
   input  logic [DEVICE_W-1:0]   req_device_uid,
   input  logic [FUNCTION_W-1:0] req_function_id,
   input  logic [SEQUENCE_W-1:0] req_sequence_number,
   input  logic                  req_response_expected,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [CLIENT_W-1:0]   rsp_routed_client,
   output logic                  rsp_broadcast,
   output logic                  rsp_dropped_oldest,
   output logic [CNT_W-1:0]      rsp_removed_count,
   output logic [CNT_W-1:0]      rsp_entries_used
);

   typedef enum logic {IDLE, SQUEEZE} state_type;

   state_type            state_ff, state_in;
   logic                 route_ff, route_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   logic [CLIENT_W-1:0]  client_ff, client_in;
   logic                 broadcast_ff, broadcast_in;
   logic                 dropped_ff, dropped_in;
   logic [CNT_W-1:0]     rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]     used_ff, used_in;

   rrt_ctrl_type         ctrl;
   rrt_entry_type        new_entry;
   rrt_entry_type        cell_entry [TABLE_DEPTH];
   logic                 cell_kill [TABLE_DEPTH];
   logic                 hole [TABLE_DEPTH+1];
   logic [CLIENT_W-1:0]  sel [TABLE_DEPTH+1];
   logic                 accept, full;

   assign new_entry = '{client: req_client_id, device: req_device_uid,
                        function_id: req_function_id, sequence_number: req_sequence_number};
   assign hole[0] = 1'b0;
   assign sel[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rrt_entry_type nb_entry;
      logic          nb_kill;
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nb_entry = cell_entry[i];
         assign nb_kill = 1'b0;
      end else begin : g_mid
         assign nb_entry = cell_entry[i+1];
         assign nb_kill = cell_kill[i+1];
      end
      rrt_cell #(
         .TABLE_DEPTH(TABLE_DEPTH),
         .INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .new_entry(new_entry),
         .count(count_ff),
         .nb_entry(nb_entry),
         .nb_kill(nb_kill),
         .hole_in(hole[i]),
         .sel_in(sel[i]),
         .entry(cell_entry[i]),
         .kill(cell_kill[i]),
         .hole_out(hole[i+1]),
         .sel_out(sel[i+1])
      );
   end

   assign req_ready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign full = count_ff == CNT_W'(TABLE_DEPTH);

   always_comb begin
      state_in = state_ff;
      route_in = route_ff;
      count_in = count_ff;
      removed_in = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in = found_ff;
      client_in = client_ff;
      broadcast_in = broadcast_ff;
      dropped_in = dropped_ff;
      rsp_removed_in = rsp_removed_ff;
      used_in = used_ff;
      ctrl = '0;
      ctrl.full = full;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               client_in = '0;
               broadcast_in = 1'b0;
               dropped_in = 1'b0;
               rsp_removed_in = '0;
               used_in = count_ff;
               case (req_operation)
                  OP_RECORD: begin
                     rsp_valid_in = 1'b1;
                     if ((req_device_uid != '0) && req_response_expected) begin
                        ctrl.record = 1'b1;
                        dropped_in = full;
                        if (!full) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                        used_in = full ? count_ff : count_ff + CNT_W'(1);
                     end
                  end
                  OP_ROUTE: begin
                     if (req_sequence_number == '0) begin
                        rsp_valid_in = 1'b1;
                        broadcast_in = 1'b1;
                     end else begin
                        ctrl.mark_route = 1'b1;
                        route_in = 1'b1;
                        state_in = SQUEEZE;
                     end
                  end
                  OP_PURGE: begin
                     ctrl.mark_purge = 1'b1;
                     route_in = 1'b0;
                     removed_in = '0;
                     state_in = SQUEEZE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         SQUEEZE: begin
            ctrl.squeeze = 1'b1;
            if (route_ff) begin
               state_in = IDLE;
               rsp_valid_in = 1'b1;
               if (hole[TABLE_DEPTH]) begin
                  found_in = 1'b1;
                  client_in = sel[TABLE_DEPTH];
                  count_in = count_ff - CNT_W'(1);
                  used_in = count_ff - CNT_W'(1);
               end else begin
                  broadcast_in = 1'b1;
                  used_in = count_ff;
               end
            end else if (hole[TABLE_DEPTH]) begin
               count_in = count_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               state_in = IDLE;
               rsp_valid_in = 1'b1;
               rsp_removed_in = removed_ff;
               used_in = count_ff;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      route_ff <= route_in;
      removed_ff <= removed_in;
      found_ff <= found_in;
      client_ff <= client_in;
      broadcast_ff <= broadcast_in;
      dropped_ff <= dropped_in;
      rsp_removed_ff <= rsp_removed_in;
      used_ff <= used_in;
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_routed_client = client_ff;
   assign rsp_broadcast = broadcast_ff;
   assign rsp_dropped_oldest = dropped_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entries_used = used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("Table occupancy exceeds its depth.");

   a_found_xor_bcast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(found_ff && broadcast_ff))
      else $error("A beat reports both a match and a broadcast.");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> (used_ff == CNT_W'(TABLE_DEPTH)))
      else $error("An eviction was reported while the table was not full.");

   a_squeeze_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQUEEZE) |-> !rsp_valid_ff)
      else $error("Result register is occupied while an operation is in progress.");

endmodule

// File: sim/response_routing_table_tb.sv
// Self-checking testbench for the response routing table, with a shadow table as predictor.
`timescale 1ns / 1ps

module response_routing_table_tb
   import rrt_pkg::*;
();

   localparam int CLOCK_HALF = 10;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_BEATS = 1800;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_OFF_START = 500;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RECENT_KEEP = 24;
   localparam int CNT_W = $clog2(RRT_TABLE_DEPTH + 1);
   localparam rrt_op_type OP_UNUSED = 2'd3;

   typedef struct packed {
      rrt_op_type            op;
      logic [CLIENT_W-1:0]   client;
      logic [DEVICE_W-1:0]   device;
      logic [FUNCTION_W-1:0] fn;
      logic [SEQUENCE_W-1:0] seq_num;
      logic                  want;
   } request_beat_type;

   typedef struct packed {
      logic                found;
      logic [CLIENT_W-1:0] client;
      logic                broadcast;
      logic                dropped;
      logic [CNT_W-1:0]    removed;
      logic [CNT_W-1:0]    used;
   } routing_reply_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_MOSTLY,
      READY_EVERY_FOURTH
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation = '0;
   logic [CLIENT_W-1:0]   req_client_id = '0;
   logic [DEVICE_W-1:0]   req_device_uid = '0;
   logic [FUNCTION_W-1:0] req_function_id = '0;
   logic [SEQUENCE_W-1:0] req_sequence_number = '0;
   logic                  req_response_expected = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [CLIENT_W-1:0]   rsp_routed_client;
   logic                  rsp_broadcast;
   logic                  rsp_dropped_oldest;
   logic [CNT_W-1:0]      rsp_removed_count;
   logic [CNT_W-1:0]      rsp_entries_used;

   rrt_entry_type shadow_entries [RRT_TABLE_DEPTH];
   int            shadow_used = 0;

   request_beat_type  pending_beats [$];
   request_beat_type  recent_keys [$];
   routing_reply_type expected_replies [$];
   request_beat_type  driven_beat = '0;
   int            beats_total = 0;
   int            accepted_beats = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   int            monitor_cycles = 0;
   int            hold_off_left = 0;
   int            mode_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [CLIENT_W-1:0] client_pool [4];
   logic [DEVICE_W-1:0] device_pool [3];

   response_routing_table i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_client_id         (req_client_id),
      .req_device_uid        (req_device_uid),
      .req_function_id       (req_function_id),
      .req_sequence_number   (req_sequence_number),
      .req_response_expected (req_response_expected),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_found             (rsp_found),
      .rsp_routed_client     (rsp_routed_client),
      .rsp_broadcast         (rsp_broadcast),
      .rsp_dropped_oldest    (rsp_dropped_oldest),
      .rsp_removed_count     (rsp_removed_count),
      .rsp_entries_used      (rsp_entries_used)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic void remove_shadow_entry(int pos);
      for (int k = pos; k + 1 < shadow_used; k++) begin
         shadow_entries[k] = shadow_entries[k + 1];
      end
      shadow_used--;
   endfunction

   function automatic routing_reply_type apply_to_shadow_table(request_beat_type b);
      routing_reply_type r;
      int hit;
      int kept;
      r = '0;
      hit = -1;
      kept = 0;
      case (b.op)
         OP_RECORD: begin
            if (b.device != '0 && b.want) begin
               if (shadow_used == RRT_TABLE_DEPTH) begin
                  remove_shadow_entry(0);
                  r.dropped = 1'b1;
               end
               shadow_entries[shadow_used] = '{b.client, b.device, b.fn, b.seq_num};
               shadow_used++;
            end
         end
         OP_ROUTE: begin
            if (b.seq_num != '0) begin
               for (int k = 0; k < shadow_used && hit < 0; k++) begin
                  if (shadow_entries[k].device == b.device &&
                      shadow_entries[k].function_id == b.fn &&
                      shadow_entries[k].sequence_number == b.seq_num) begin
                     hit = k;
                  end
               end
            end
            if (hit >= 0) begin
               r.found = 1'b1;
               r.client = shadow_entries[hit].client;
               remove_shadow_entry(hit);
            end else begin
               r.broadcast = 1'b1;
            end
         end
         OP_PURGE: begin
            for (int k = 0; k < shadow_used; k++) begin
               if (shadow_entries[k].client == b.client) begin
                  r.removed++;
               end else begin
                  shadow_entries[kept] = shadow_entries[k];
                  kept++;
               end
            end
            shadow_used = kept;
         end
         default: begin
         end
      endcase
      r.used = CNT_W'(shadow_used);
      return r;
   endfunction

   function automatic request_beat_type make_beat(rrt_op_type op,
                                                  logic [CLIENT_W-1:0] client,
                                                  logic [DEVICE_W-1:0] device,
                                                  logic [FUNCTION_W-1:0] fn,
                                                  logic [SEQUENCE_W-1:0] seq_num,
                                                  logic want);
      request_beat_type b;
      b = '{op, client, device, fn, seq_num, want};
      return b;
   endfunction

   function automatic logic [CLIENT_W-1:0] pick_client();
      if ($urandom_range(0, 9) < 7) begin
         return client_pool[$urandom_range(0, 3)];
      end
      return $urandom();
   endfunction

   function automatic logic [DEVICE_W-1:0] pick_device();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         return device_pool[$urandom_range(0, 2)];
      end else if (r < 9) begin
         return $urandom();
      end
      return '0;
   endfunction

   function automatic logic [FUNCTION_W-1:0] pick_function();
      if ($urandom_range(0, 9) < 6) begin
         return FUNCTION_W'($urandom_range(0, 3));
      end
      return FUNCTION_W'($urandom_range(0, 255));
   endfunction

   task automatic queue_random_beat();
      request_beat_type b;
      int r;
      r = $urandom_range(0, 99);
      if (r < 48) begin
         b = make_beat(OP_RECORD, pick_client(), pick_device(), pick_function(),
                       SEQUENCE_W'($urandom_range(0, 15)), $urandom_range(0, 9) != 0);
         recent_keys.push_back(b);
         if (recent_keys.size() > RECENT_KEEP) begin
            void'(recent_keys.pop_front());
         end
      end else if (r < 88) begin
         if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
            b = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            b.op = OP_ROUTE;
            b.client = $urandom();
            b.want = 1'($urandom_range(0, 1));
         end else begin
            b = make_beat(OP_ROUTE, $urandom(), pick_device(), pick_function(),
                          SEQUENCE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 9) == 0) begin
            b.seq_num = '0;
         end
      end else if (r < 97) begin
         b = make_beat(OP_PURGE, pick_client(), $urandom(), FUNCTION_W'($urandom_range(0, 255)),
                       SEQUENCE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
         b = make_beat(OP_UNUSED, $urandom(), $urandom(), FUNCTION_W'($urandom_range(0, 255)),
                       SEQUENCE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      pending_beats.push_back(b);
   endtask

   function automatic void compare_field(string name, logic [CLIENT_W-1:0] expected_value,
                                         logic [CLIENT_W-1:0] actual_value);
      if (actual_value !== expected_value) begin
         $display("%0t: %s expected %h, actual %h", $time, name, expected_value, actual_value);
         mismatch_count++;
      end
   endfunction

   task automatic check_reply();
      routing_reply_type e;
      if (expected_replies.size() == 0) begin
         $display("%0t: reply beat with nothing expected, expected none, actual client %h",
                  $time, rsp_routed_client);
         mismatch_count++;
      end else begin
         e = expected_replies.pop_front();
         compare_field("found", CLIENT_W'(e.found), CLIENT_W'(rsp_found));
         compare_field("routed_client", e.client, rsp_routed_client);
         compare_field("broadcast", CLIENT_W'(e.broadcast), CLIENT_W'(rsp_broadcast));
         compare_field("dropped_oldest", CLIENT_W'(e.dropped), CLIENT_W'(rsp_dropped_oldest));
         compare_field("removed_count", CLIENT_W'(e.removed), CLIENT_W'(rsp_removed_count));
         compare_field("entries_used", CLIENT_W'(e.used), CLIENT_W'(rsp_entries_used));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(apply_to_shadow_table(driven_beat));
            accepted_beats++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               driven_beat = pending_beats.pop_front();
               req_operation <= driven_beat.op;
               req_client_id <= driven_beat.client;
               req_device_uid <= driven_beat.device;
               req_function_id <= driven_beat.fn;
               req_sequence_number <= driven_beat.seq_num;
               req_response_expected <= driven_beat.want;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reply();
         end
         monitor_cycles++;
         if (monitor_cycles == HOLD_OFF_START) begin
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF: rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_ready <= $urandom_range(0, 4) != 0;
               default: rsp_ready <= (monitor_cycles % 4) == 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("response_routing_table_tb: done, errors");
         $finish;
      end
   end

   initial begin
      client_pool[0] = '0;
      client_pool[1] = '1;
      client_pool[2] = $urandom();
      client_pool[3] = $urandom();
      for (int k = 0; k < 3; k++) begin
         device_pool[k] = $urandom() | 32'h1;
      end

      // Records that are not kept, an all-ones entry, the three kinds of route on it, a purge and an unused code.
      pending_beats.push_back(make_beat(OP_RECORD, client_pool[2], '0, 8'h01, 4'h1, 1'b1));
      pending_beats.push_back(make_beat(OP_RECORD, client_pool[2], device_pool[0], 8'h01,
                                        4'h1, 1'b0));
      pending_beats.push_back(make_beat(OP_RECORD, '1, '1, '1, '1, 1'b1));
      pending_beats.push_back(make_beat(OP_ROUTE, '0, '1, '1, '0, 1'b0));
      pending_beats.push_back(make_beat(OP_ROUTE, '0, '1, '1, 4'hE, 1'b0));
      pending_beats.push_back(make_beat(OP_ROUTE, '0, '1, '1, '1, 1'b0));
      pending_beats.push_back(make_beat(OP_PURGE, client_pool[2], '0, '0, '0, 1'b0));
      pending_beats.push_back(make_beat(OP_UNUSED, '1, '1, '1, '1, 1'b1));
      // Fill the table past its depth so the oldest entry is evicted, then purge one client.
      for (int k = 0; k <= RRT_TABLE_DEPTH; k++) begin
         pending_beats.push_back(make_beat(OP_RECORD, client_pool[2 + (k % 2)],
                                           device_pool[k % 3], FUNCTION_W'(k),
                                           SEQUENCE_W'((k % 15) + 1), 1'b1));
      end
      pending_beats.push_back(make_beat(OP_PURGE, client_pool[2], '0, '0, '0, 1'b0));

      for (int k = 0; k < RANDOM_BEATS; k++) begin
         queue_random_beat();
      end
      beats_total = pending_beats.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_beats < beats_total) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("response_routing_table_tb: done, clean");
      end else begin
         $display("response_routing_table_tb: done, errors");
      end
      $finish;
   end

endmodule
